// ===== rtl/mcg_pkg.sv =====
// Shared types and codes for the Markov candidate generator.
package mcg_pkg;

  // Request action codes
  localparam logic [1:0] ACT_WR_CHAR = 2'd0;
  localparam logic [1:0] ACT_WR_LEN  = 2'd1;
  localparam logic [1:0] ACT_GEN     = 2'd2;
  localparam logic [1:0] ACT_KEYS    = 2'd3;

  // Table select codes
  localparam logic TSEL_ROOT   = 1'b0;
  localparam logic TSEL_MARKOV = 1'b1;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_KEYS = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic        table_sel;
    logic [3:0]  position;
    logic [7:0]  prev_char;
    logic [3:0]  slot;
    logic [7:0]  char_value;
    logic [4:0]  set_length;
    logic [63:0] cand_index;
    logic [3:0]  start_pos;
    logic [4:0]  stop_pos;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  out_char;
    logic [63:0] keyspace;
    logic        zero_set_error;
    logic        last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_step;
    logic ks_step;
    logic ks_emit;
    logic div_init;
    logic div_step;
    logic char_rd;
    logic emit_char;
    logic emit_err;
    logic next_pos;
    logic len_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic act_gen;
    logic act_keys;
    logic gen_empty;
    logic ks_more;
    logic set_empty;
    logic div_last;
    logic at_last;
    logic ch_in_alpha;
  } stat_t;

endpackage

// ===== rtl/mcg_ctrl.sv =====
// Sequencer for clearing, keyspace products and character generation.
module mcg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mcg_pkg::stat_t st_i,
  output mcg_pkg::cmd_t  cmd_o
);
  import mcg_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_KS    = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_RDCH  = 9'b000100000,
    S_EMIT  = 9'b001000000,
    S_NEXT  = 9'b010000000,
    S_RDLEN = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (st_i.act_gen && !st_i.gen_empty) state_d = S_CHK;
          else if (st_i.act_keys) state_d = S_KS;
        end
      end
      S_KS: begin
        if (st_i.ks_more) begin
          cmd_o.ks_step = 1'b1;
        end else begin
          cmd_o.ks_emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CHK: begin
        if (st_i.set_empty) begin
          cmd_o.emit_err = 1'b1;
          state_d = S_NEXT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) state_d = S_RDCH;
      end
      S_RDCH: begin
        cmd_o.char_rd = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_char = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.next_pos = 1'b1;
        if (st_i.at_last) state_d = S_IDLE;
        else if (st_i.ch_in_alpha) state_d = S_RDLEN;
        else state_d = S_CHK;
      end
      S_RDLEN: begin
        cmd_o.len_load = 1'b1;
        state_d = S_CHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/mcg_dp.sv =====
// Datapath: set tables, bit-serial divider, keyspace multiplier, result register.
module mcg_dp #(
  parameter int MAX_LEN  = 16,
  parameter int ALPHABET = 256,
  parameter int MAX_SET  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcg_pkg::req_t  req_i,
  input  mcg_pkg::cmd_t  cmd_i,
  output mcg_pkg::stat_t st_o,
  output mcg_pkg::res_t  res_o,
  output logic           res_valid_o
);
  import mcg_pkg::*;

  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW  = $clog2(ALPHABET);
  localparam int SW  = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int LW  = $clog2(MAX_SET + 1);
  localparam int MLA = PW + CW;
  localparam int RCA = PW + SW;
  localparam int MCA = PW + CW + SW;

  // Tables
  logic [LW-1:0] root_len_q [MAX_LEN];
  logic [7:0]    rc_mem [2**RCA];
  logic [7:0]    mc_mem [2**MCA];
  logic [LW-1:0] ml_mem [2**MLA];

  logic [7:0]    rc_rd_q, mc_rd_q;
  logic [LW-1:0] ml_rd_q;
  logic [MLA-1:0] clr_q;

  // Working registers
  logic [4:0]    pos_q, stop_q;
  logic [63:0]   idx_q, prod_q;
  logic [LW-1:0] rem_q, len_q;
  logic          have_q, root_q, kerr_q;
  logic [CW-1:0] prev_q;
  logic [7:0]    ch_q;
  logic [5:0]    cnt_q;
  res_t          res_q;
  logic          vld_q;

  // Request decode
  logic [4:0]    stop_clip;
  logic [LW-1:0] slen_sat;
  logic          pos_ok, slot_ok, prev_ok;
  logic          wr_char, wr_len;

  assign stop_clip = (32'(req_i.stop_pos) > MAX_LEN) ? 5'(MAX_LEN) : req_i.stop_pos;
  assign slen_sat  = (32'(req_i.set_length) > MAX_SET) ? LW'(MAX_SET)
                                                         : LW'(req_i.set_length);
  assign pos_ok  = 32'(req_i.position) < MAX_LEN;
  assign slot_ok = 32'(req_i.slot) < MAX_SET;
  assign prev_ok = 32'(req_i.prev_char) < ALPHABET;
  assign wr_char = cmd_i.load && (req_i.action == ACT_WR_CHAR) && pos_ok && slot_ok;
  assign wr_len  = cmd_i.load && (req_i.action == ACT_WR_LEN) && pos_ok;

  // Root length read port
  logic [PW-1:0] rl_addr;
  logic [LW-1:0] rl_data;
  assign rl_addr = cmd_i.load ? PW'(req_i.start_pos) : PW'(pos_q);
  assign rl_data = root_len_q[rl_addr];

  // Divider step
  logic [LW:0]   div_t;
  logic          div_ge;
  logic [LW:0]   div_sub;
  assign div_t   = {rem_q, idx_q[63]};
  assign div_ge  = div_t >= {1'b0, len_q};
  assign div_sub = div_t - {1'b0, len_q};

  logic [7:0] rd_char;
  assign rd_char = root_q ? rc_rd_q : mc_rd_q;

  // Markov set of the current position belongs to the previous position
  logic [4:0] prev_pos;
  assign prev_pos = pos_q - 5'd1;

  // Status
  assign st_o.clr_last    = &clr_q;
  assign st_o.act_gen     = (req_i.action == ACT_GEN);
  assign st_o.act_keys    = (req_i.action == ACT_KEYS);
  assign st_o.gen_empty   = {1'b0, req_i.start_pos} >= stop_clip;
  assign st_o.ks_more     = pos_q < stop_q;
  assign st_o.set_empty   = !have_q || (len_q == '0);
  assign st_o.div_last    = &cnt_q;
  assign st_o.at_last     = (pos_q + 5'd1) == stop_q;
  assign st_o.ch_in_alpha = 32'(ch_q) < ALPHABET;

  // Root lengths: flops cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEN; i++) root_len_q[i] <= '0;
    end else if (wr_len && req_i.table_sel == TSEL_ROOT) begin
      root_len_q[PW'(req_i.position)] <= slen_sat;
    end
  end

  // Root characters
  always_ff @(posedge clk_i) begin
    if (wr_char && req_i.table_sel == TSEL_ROOT) begin
      rc_mem[{PW'(req_i.position), SW'(req_i.slot)}] <= req_i.char_value;
    end
    if (cmd_i.char_rd) begin
      rc_rd_q <= rc_mem[{PW'(pos_q), SW'(rem_q)}];
    end
  end

  // Markov characters
  always_ff @(posedge clk_i) begin
    if (wr_char && req_i.table_sel == TSEL_MARKOV && prev_ok) begin
      mc_mem[{PW'(req_i.position), CW'(req_i.prev_char), SW'(req_i.slot)}] <=
        req_i.char_value;
    end
    if (cmd_i.char_rd) begin
      mc_rd_q <= mc_mem[{PW'(prev_pos), prev_q, SW'(rem_q)}];
    end
  end

  // Markov lengths: cleared by a sweep after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      ml_mem[clr_q] <= '0;
    end else if (wr_len && req_i.table_sel == TSEL_MARKOV && prev_ok) begin
      ml_mem[{PW'(req_i.position), CW'(req_i.prev_char)}] <= slen_sat;
    end
    if (cmd_i.next_pos) begin
      ml_rd_q <= ml_mem[{PW'(pos_q), CW'(ch_q)}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q  <= {1'b0, req_i.start_pos};
      stop_q <= stop_clip;
      idx_q  <= req_i.cand_index;
      len_q  <= rl_data;
      have_q <= 1'b1;
      root_q <= 1'b1;
      prod_q <= 64'd1;
      kerr_q <= 1'b0;
    end
    if (cmd_i.ks_step) begin
      prod_q <= prod_q * rl_data;
      kerr_q <= kerr_q | (rl_data == '0);
      pos_q  <= pos_q + 5'd1;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_sub[LW-1:0] : div_t[LW-1:0];
      idx_q <= {idx_q[62:0], div_ge};
      cnt_q <= cnt_q + 6'd1;
    end
    if (cmd_i.emit_err) ch_q <= 8'd0;
    if (cmd_i.emit_char) ch_q <= rd_char;
    if (cmd_i.next_pos) begin
      pos_q  <= pos_q + 5'd1;
      root_q <= 1'b0;
      if (st_o.ch_in_alpha) begin
        prev_q <= CW'(ch_q);
      end else begin
        have_q <= 1'b0;
        len_q  <= '0;
      end
    end
    if (cmd_i.len_load) begin
      len_q  <= ml_rd_q;
      have_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_emit) begin
      res_q <= '{result_kind: KIND_KEYS, out_char: 8'd0, keyspace: prod_q,
                 zero_set_error: kerr_q, last: 1'b1};
    end else if (cmd_i.emit_err || cmd_i.emit_char) begin
      res_q <= '{result_kind: KIND_CHAR,
                 out_char: cmd_i.emit_char ? rd_char : 8'd0,
                 keyspace: 64'd0, zero_set_error: cmd_i.emit_err,
                 last: st_o.at_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.ks_emit | cmd_i.emit_err | cmd_i.emit_char;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = vld_q;

endmodule

// ===== rtl/markov_candidate_generator_core.sv =====
// Top level of the Markov candidate generator: controller plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------
//  request  | start / busy        | req_i  (req_t)
//  result   | res_valid_o strobe  | res_o  (res_t)
//
// A keyspace request makes one multiply per position. A generate request
// runs, per position with a nonempty set, a check, 64 divider steps, a table
// read, the emit, the advance and a Markov length read (the final position
// skips the length read); an empty set gets a check that emits the error,
// the advance and, unless at the final position, the length read.
// After reset a clearing pass zeroes the Markov length memory, one entry a
// cycle, over 2**(clog2(MAX_LEN)+clog2(ALPHABET)) entries (4096 by default), busy high.
// The receiver cannot stall: each result is shown for one cycle.
module markov_candidate_generator_core #(
  parameter int MAX_LEN  = 16,
  parameter int ALPHABET = 256,
  parameter int MAX_SET  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mcg_pkg::req_t req_i,
  output mcg_pkg::res_t res_o,
  output logic          res_valid_o
);
  import mcg_pkg::*;

  cmd_t  cmd;
  stat_t st;

  mcg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  mcg_dp #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET),
    .MAX_SET  (MAX_SET)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// ===== tb/tb_markov_candidate_generator_core.sv =====
// Self-checking testbench for the Markov candidate generator core.
module tb_markov_candidate_generator_core;
  import mcg_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  res_t res_o;
  logic res_valid_o;

  markov_candidate_generator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_o(res_o), .res_valid_o(res_valid_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the set tables
  bit [7:0]  root_ch [16][16];
  bit [4:0]  root_len[16];
  bit [15:0] root_wr [16];
  bit [7:0]  mk_ch   [16][256][16];
  bit [4:0]  mk_len  [16][256];
  bit [15:0] mk_wr   [16][256];

  res_t pending_results[$];
  int   errors = 0;
  int   n_requests = 0;
  int   n_chars = 0;
  int   n_keys = 0;
  int   n_set_errs = 0;
  int   idle_pct = 0;
  bit   driving = 1'b0;

  // Update the shadow tables and queue the results a request should produce
  task automatic predict_request(req_t r);
    int        stop_e, slen, len, i;
    bit [63:0] idx, prod;
    bit [7:0]  ch;
    bit        err;
    res_t      e;
    stop_e = (r.stop_pos > 16) ? 16 : int'(r.stop_pos);
    slen   = (r.set_length > 16) ? 16 : int'(r.set_length);
    case (r.action)
      ACT_WR_CHAR: begin
        if (r.table_sel == TSEL_ROOT) begin
          root_ch[r.position][r.slot] = r.char_value;
          root_wr[r.position][r.slot] = 1'b1;
        end else begin
          mk_ch[r.position][r.prev_char][r.slot] = r.char_value;
          mk_wr[r.position][r.prev_char][r.slot] = 1'b1;
        end
      end
      ACT_WR_LEN: begin
        if (r.table_sel == TSEL_ROOT) root_len[r.position] = 5'(slen);
        else mk_len[r.position][r.prev_char] = 5'(slen);
      end
      ACT_KEYS: begin
        prod = 64'd1;
        err  = 1'b0;
        for (i = r.start_pos; i < stop_e; i++) begin
          prod = prod * root_len[i];
          if (root_len[i] == 0) err = 1'b1;
        end
        e = '{result_kind: KIND_KEYS, out_char: 8'd0, keyspace: prod,
              zero_set_error: err, last: 1'b1};
        pending_results.push_back(e);
      end
      default: begin
        idx = r.cand_index;
        ch  = 8'd0;
        len = int'(root_len[r.start_pos]);
        for (i = r.start_pos; i < stop_e; i++) begin
          err = (len == 0);
          if (err) begin
            ch = 8'd0;
          end else begin
            ch = (i == r.start_pos) ? root_ch[i][idx % 64'(len)]
                                    : mk_ch[i-1][ch][idx % 64'(len)];
            idx = idx / 64'(len);
          end
          e = '{result_kind: KIND_CHAR, out_char: ch, keyspace: 64'd0,
                zero_set_error: err, last: (i + 1 == stop_e)};
          pending_results.push_back(e);
          len = int'(mk_len[i][ch]);
        end
      end
    endcase
  endtask

  // Drive one request, wait for acceptance, then predict it
  task automatic send_request(req_t r);
    if (driving && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    driving = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(r);
    n_requests++;
  endtask

  task automatic drain;
    start <= 1'b0;
    driving = 1'b0;
    @(posedge clk_i);
    while (busy || pending_results.size() != 0) @(posedge clk_i);
    // writes give no result; let the last one settle
    repeat (20) @(posedge clk_i);
  endtask

  function automatic req_t random_fields();
    req_t r;
    r = '{action: 2'($urandom), table_sel: 1'($urandom), position: 4'($urandom),
          prev_char: 8'($urandom), slot: 4'($urandom), char_value: 8'($urandom),
          set_length: 5'($urandom), cand_index: {$urandom, $urandom},
          start_pos: 4'($urandom), stop_pos: 5'($urandom)};
    return r;
  endfunction

  function automatic int written_prefix(bit [15:0] m);
    int n;
    n = 0;
    while (n < 16 && m[n]) n++;
    return n;
  endfunction

  task automatic write_char(bit tsel, int pos, int prev, int slot, int val);
    req_t r;
    r = random_fields();
    r.action = ACT_WR_CHAR; r.table_sel = tsel; r.position = 4'(pos);
    r.prev_char = 8'(prev); r.slot = 4'(slot); r.char_value = 8'(val);
    send_request(r);
  endtask

  // Length write, clipped so that no unwritten slot becomes readable
  task automatic write_len(bit tsel, int pos, int prev, int len);
    req_t r;
    int   lim;
    lim = written_prefix(tsel == TSEL_ROOT ? root_wr[pos] : mk_wr[pos][prev]);
    if (len > lim) len = lim;
    r = random_fields();
    r.action = ACT_WR_LEN; r.table_sel = tsel; r.position = 4'(pos);
    r.prev_char = 8'(prev);
    r.set_length = (len == 16) ? 5'($urandom_range(31, 16)) : 5'(len);
    send_request(r);
  endtask

  task automatic gen_or_keys(bit [1:0] act, int s, int e, bit [63:0] idx);
    req_t r;
    r = random_fields();
    r.action = act; r.start_pos = 4'(s); r.stop_pos = 5'(e); r.cand_index = idx;
    send_request(r);
  endtask

  // Extremes and corner cases from a freshly reset table
  task automatic test_directed;
    int k;
    gen_or_keys(ACT_KEYS, 0, 16, 64'd5);
    gen_or_keys(ACT_GEN, 3, 3, '1);
    gen_or_keys(ACT_GEN, 5, 2, '1);
    gen_or_keys(ACT_KEYS, 7, 7, 64'd0);
    gen_or_keys(ACT_GEN, 0, 2, 64'd9);
    for (k = 0; k < 16; k++)
      write_char(TSEL_ROOT, 15, 0, k, (k == 15) ? 255 : k * 13);
    write_len(TSEL_ROOT, 15, 0, 16);
    gen_or_keys(ACT_GEN, 15, 31, '1);
    gen_or_keys(ACT_KEYS, 15, 31, 64'd0);
    drain();
  endtask

  // Small windows of chained sets, then generates walking through them, mixed with keyspace requests and random writes
  task automatic test_chain_phase(int pct, int n_ops);
    int        base, p, c, k, n, s;
    bit [7:0]  pool[3];
    bit [63:0] idx;
    idle_pct = pct;
    base = $urandom_range(11);
    pool[0] = 8'($urandom);
    pool[1] = pool[0] + 8'($urandom_range(255, 1));
    do pool[2] = 8'($urandom); while (pool[2] == pool[0] || pool[2] == pool[1]);
    n = $urandom_range(3, 1);
    for (k = 0; k < n; k++) write_char(TSEL_ROOT, base, 0, k, pool[$urandom_range(2)]);
    write_len(TSEL_ROOT, base, 0, n);
    for (p = base; p < base + 4; p++) begin
      for (c = 0; c < 3; c++) begin
        n = $urandom_range(3);
        for (k = 0; k < n; k++)
          write_char(TSEL_MARKOV, p, pool[c], k, pool[$urandom_range(2)]);
        write_len(TSEL_MARKOV, p, pool[c], (n == 0) ? 0 : $urandom_range(n, 1));
      end
    end
    for (k = 0; k < n_ops; k++) begin
      idx = ($urandom_range(1)) ? 64'($urandom_range(50)) : {$urandom, $urandom};
      n = $urandom_range(99);
      if (k == n_ops / 2) drain();
      if (n < 65) begin
        s = base + (($urandom_range(3) == 0) ? $urandom_range(3) : 0);
        gen_or_keys(ACT_GEN, s, ($urandom_range(9) == 0) ? $urandom_range(31, 17)
                                                         : s + $urandom_range(5), idx);
      end else if (n < 80) begin
        s = $urandom_range(15);
        gen_or_keys(ACT_KEYS, s, $urandom_range(31), idx);
      end else if (n < 90) begin
        write_char(1'($urandom), $urandom_range(15), $urandom_range(255),
                   $urandom_range(15), $urandom_range(255));
      end else begin
        write_len(1'($urandom), $urandom_range(15), $urandom_range(255),
                  $urandom_range(16));
      end
    end
    drain();
  endtask

  // Compare each result against the oldest prediction
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res_o !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, res_o);
          errors++;
        end
        if (e.result_kind == KIND_KEYS) n_keys++;
        else n_chars++;
        if (e.zero_set_error) n_set_errs++;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_chain_phase(0, 45);
    test_chain_phase(48, 45);
    test_chain_phase(26, 45);
    test_chain_phase(0, 45);
    test_chain_phase(48, 45);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d requests: %0d candidate chars, %0d keyspace results,",
             n_requests, n_chars, n_keys);
    $display("%0d of them flagged an empty set.", n_set_errs);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
